[design/mrpt_pkg.sv]
// ----------------------------------------------------------------------------
// mrpt_pkg
// Shared types and fixed field widths for the Miller-Rabin test unit.
// ----------------------------------------------------------------------------
package mrpt_pkg;

    // stream field widths
    localparam int CAND_W     = 64;
    localparam int RAND_W     = 31;
    localparam int S_TDATA_W  = 160;
    localparam int M_TDATA_W  = 8;

    // bit counter for the serial base reduction
    localparam int RCNT_W     = $clog2(RAND_W);

    // number of rounds and the width of the round counter
    localparam int ROUNDS     = 3;
    localparam int ROUND_W    = 2;

    // sequencer states
    typedef enum logic [6:0] {
        ST_IDLE     = 7'b0000001,
        ST_DECOMP   = 7'b0000010,
        ST_BASE_DIV = 7'b0000100,
        ST_POW      = 7'b0001000,
        ST_MUL      = 7'b0010000,
        ST_SQ       = 7'b0100000,
        ST_FINISH   = 7'b1000000
    } state_t;

    // where a finished modular product goes
    typedef enum logic [2:0] {
        DST_ACC  = 3'b001,
        DST_BASE = 3'b010,
        DST_SQ   = 3'b100
    } mul_dst_t;

endpackage

[design/miller_rabin_primality_test_unit.sv]
// ----------------------------------------------------------------------------
// miller_rabin_primality_test_unit
// Three-round Miller-Rabin probable-prime test with a bit-serial modular
// multiplier and a bit-serial base reduction.
// ----------------------------------------------------------------------------
// One candidate is tested at a time; s_tready is high only while the unit is
// idle, and a finished answer waits in the output register without blocking
// the next input transfer. Candidates that are negative, below 2 or even are
// answered straight from idle through the finish state. For an odd candidate,
// n-1 is split into m * 2^k one bit a cycle, each round reduces its random
// word modulo n-2 to pick its base, and then runs square-and-multiply on a
// single shift-and-add multiplier that consumes one multiplier bit per cycle
// (up to two products per exponent bit, plus up to k squarings). That
// multiplier sets the rate. Only the low WORD_BITS bits of the candidate are
// used, read as a signed number of that width.
module miller_rabin_primality_test_unit #(
    parameter int WORD_BITS = 64
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [63:0] candidate, [94:64] random_first, [125:95] random_second,
    // [156:126] random_third, [159:157] zero
    input  logic [mrpt_pkg::S_TDATA_W-1:0]  s_tdata,
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [0] probably_prime, [7:1] zero
    output logic [mrpt_pkg::M_TDATA_W-1:0]  m_tdata
);

    localparam int W  = WORD_BITS;
    localparam int KW = $clog2(WORD_BITS);

    mrpt_pkg::state_t   state_reg, state_next;
    mrpt_pkg::mul_dst_t dst_reg, dst_next;

    logic [W-1:0]                    n_reg, n_next;
    logic [W-1:0]                    m_reg, m_next;
    logic [KW-1:0]                   k_reg, k_next;
    logic [KW-1:0]                   i_reg, i_next;
    logic [W-1:0]                    e_reg, e_next;
    logic [W-1:0]                    acc_reg, acc_next;
    logic [W-1:0]                    base_reg, base_next;
    logic [W-1:0]                    rem_reg, rem_next;
    logic [mrpt_pkg::RAND_W-1:0]     rnd_a_reg, rnd_a_next;
    logic [mrpt_pkg::RAND_W-1:0]     rnd_b_reg, rnd_b_next;
    logic [mrpt_pkg::RAND_W-1:0]     rnd_c_reg, rnd_c_next;
    logic [mrpt_pkg::RCNT_W-1:0]     rcnt_reg, rcnt_next;
    logic [mrpt_pkg::ROUND_W-1:0]    round_reg, round_next;
    logic [W-1:0]                    macc_reg, macc_next;
    logic [W-1:0]                    madd_reg, madd_next;
    logic [W-1:0]                    my_reg, my_next;
    logic                            result_reg, result_next;
    logic                            out_valid_reg, out_valid_next;
    logic                            out_bit_reg, out_bit_next;

    logic [W-1:0] n_in;
    logic [W-1:0] n_minus1;
    logic [W:0]   div_shift;
    logic [W:0]   div_d;
    logic [W-1:0] div_rem;
    logic [W:0]   mul_sum;
    logic [W-1:0] mul_acc_step;
    logic [W:0]   mul_dbl;
    logic [W-1:0] mul_add_step;
    logic         s_xfer;

    assign s_tready = (state_reg == mrpt_pkg::ST_IDLE);
    assign s_xfer   = s_tvalid & s_tready;
    assign n_in     = s_tdata[W-1:0];
    assign n_minus1 = n_reg - W'(1);

    // one restoring division step of the random word by n-2
    assign div_shift = {rem_reg, rnd_a_reg[mrpt_pkg::RAND_W-1]};
    assign div_d     = {1'b0, n_reg - W'(2)};
    assign div_rem   = (div_shift >= div_d) ? W'(div_shift - div_d) : div_shift[W-1:0];

    // one shift-and-add step of the modular multiplier
    assign mul_sum      = {1'b0, macc_reg} + {1'b0, madd_reg};
    assign mul_acc_step = !my_reg[0] ? macc_reg :
                          (mul_sum >= {1'b0, n_reg}) ? W'(mul_sum - {1'b0, n_reg}) :
                          mul_sum[W-1:0];
    assign mul_dbl      = {madd_reg, 1'b0};
    assign mul_add_step = (mul_dbl >= {1'b0, n_reg}) ? W'(mul_dbl - {1'b0, n_reg}) :
                          mul_dbl[W-1:0];

    // sequencer
    always_comb begin
        logic start_div;
        logic pass_round;

        start_div      = 1'b0;
        pass_round     = 1'b0;
        state_next     = state_reg;
        dst_next       = dst_reg;
        n_next         = n_reg;
        m_next         = m_reg;
        k_next         = k_reg;
        i_next         = i_reg;
        e_next         = e_reg;
        acc_next       = acc_reg;
        base_next      = base_reg;
        rem_next       = rem_reg;
        rnd_a_next     = rnd_a_reg;
        rnd_b_next     = rnd_b_reg;
        rnd_c_next     = rnd_c_reg;
        rcnt_next      = rcnt_reg;
        round_next     = round_reg;
        macc_next      = macc_reg;
        madd_next      = madd_reg;
        my_next        = my_reg;
        result_next    = result_reg;
        out_valid_next = out_valid_reg & ~m_tready;
        out_bit_next   = out_bit_reg;

        case (state_reg)
            mrpt_pkg::ST_IDLE: begin
                if (s_xfer) begin
                    n_next     = n_in;
                    rnd_a_next = s_tdata[mrpt_pkg::CAND_W +: mrpt_pkg::RAND_W];
                    rnd_b_next = s_tdata[mrpt_pkg::CAND_W + mrpt_pkg::RAND_W +:
                                         mrpt_pkg::RAND_W];
                    rnd_c_next = s_tdata[mrpt_pkg::CAND_W + 2*mrpt_pkg::RAND_W +:
                                         mrpt_pkg::RAND_W];
                    round_next = '0;
                    // trivial candidates are settled at once
                    if (n_in[W-1] || (n_in < W'(2))) begin
                        result_next = 1'b0;
                        state_next  = mrpt_pkg::ST_FINISH;
                    end else if (n_in == W'(2)) begin
                        result_next = 1'b1;
                        state_next  = mrpt_pkg::ST_FINISH;
                    end else if (!n_in[0]) begin
                        result_next = 1'b0;
                        state_next  = mrpt_pkg::ST_FINISH;
                    end else begin
                        m_next     = n_in - W'(1);
                        k_next     = '0;
                        state_next = mrpt_pkg::ST_DECOMP;
                    end
                end
            end
            // strip factors of two from n-1
            mrpt_pkg::ST_DECOMP: begin
                if (m_reg[0]) begin
                    start_div = 1'b1;
                end else begin
                    m_next = m_reg >> 1;
                    k_next = k_reg + KW'(1);
                end
            end
            // random word mod (n-2), most significant bit first
            mrpt_pkg::ST_BASE_DIV: begin
                rem_next   = div_rem;
                rnd_a_next = rnd_a_reg << 1;
                if (rcnt_reg == '0) begin
                    base_next  = div_rem + W'(2);
                    acc_next   = W'(1);
                    e_next     = m_reg;
                    state_next = mrpt_pkg::ST_POW;
                end else begin
                    rcnt_next = rcnt_reg - mrpt_pkg::RCNT_W'(1);
                end
            end
            // square-and-multiply over the exponent bits
            mrpt_pkg::ST_POW: begin
                if (e_reg == '0) begin
                    if (acc_reg == W'(1)) begin
                        pass_round = 1'b1;
                    end else begin
                        i_next     = '0;
                        state_next = mrpt_pkg::ST_SQ;
                    end
                end else if (e_reg[0]) begin
                    macc_next  = '0;
                    madd_next  = acc_reg;
                    my_next    = base_reg;
                    dst_next   = mrpt_pkg::DST_ACC;
                    state_next = mrpt_pkg::ST_MUL;
                end else begin
                    macc_next  = '0;
                    madd_next  = base_reg;
                    my_next    = base_reg;
                    dst_next   = mrpt_pkg::DST_BASE;
                    state_next = mrpt_pkg::ST_MUL;
                end
            end
            // shift-and-add modular product, one multiplier bit per cycle
            mrpt_pkg::ST_MUL: begin
                if (my_reg == '0) begin
                    case (dst_reg)
                        mrpt_pkg::DST_ACC: begin
                            acc_next  = macc_reg;
                            macc_next = '0;
                            madd_next = base_reg;
                            my_next   = base_reg;
                            dst_next  = mrpt_pkg::DST_BASE;
                        end
                        mrpt_pkg::DST_BASE: begin
                            base_next  = macc_reg;
                            e_next     = e_reg >> 1;
                            state_next = mrpt_pkg::ST_POW;
                        end
                        mrpt_pkg::DST_SQ: begin
                            acc_next   = macc_reg;
                            i_next     = i_reg + KW'(1);
                            state_next = mrpt_pkg::ST_SQ;
                        end
                        default: begin
                            state_next = mrpt_pkg::ST_IDLE;
                        end
                    endcase
                end else begin
                    macc_next = mul_acc_step;
                    madd_next = mul_add_step;
                    my_next   = my_reg >> 1;
                end
            end
            // up to k squarings looking for n-1
            mrpt_pkg::ST_SQ: begin
                if (i_reg >= k_reg) begin
                    result_next = 1'b0;
                    state_next  = mrpt_pkg::ST_FINISH;
                end else if (acc_reg == n_minus1) begin
                    pass_round = 1'b1;
                end else begin
                    macc_next  = '0;
                    madd_next  = acc_reg;
                    my_next    = acc_reg;
                    dst_next   = mrpt_pkg::DST_SQ;
                    state_next = mrpt_pkg::ST_MUL;
                end
            end
            // hand the answer to the output register once it is free
            mrpt_pkg::ST_FINISH: begin
                if (!out_valid_reg || m_tready) begin
                    out_valid_next = 1'b1;
                    out_bit_next   = result_reg;
                    state_next     = mrpt_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = mrpt_pkg::ST_IDLE;
            end
        endcase

        // round passed: answer prime after the last, else move to the next word
        if (pass_round) begin
            if (round_reg == mrpt_pkg::ROUND_W'(mrpt_pkg::ROUNDS - 1)) begin
                result_next = 1'b1;
                state_next  = mrpt_pkg::ST_FINISH;
            end else begin
                round_next = round_reg + mrpt_pkg::ROUND_W'(1);
                rnd_a_next = rnd_b_reg;
                rnd_b_next = rnd_c_reg;
                start_div  = 1'b1;
            end
        end

        if (start_div) begin
            rem_next   = '0;
            rcnt_next  = mrpt_pkg::RCNT_W'(mrpt_pkg::RAND_W - 1);
            state_next = mrpt_pkg::ST_BASE_DIV;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= mrpt_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        dst_reg    <= dst_next;
        n_reg      <= n_next;
        m_reg      <= m_next;
        k_reg      <= k_next;
        i_reg      <= i_next;
        e_reg      <= e_next;
        acc_reg    <= acc_next;
        base_reg   <= base_next;
        rem_reg    <= rem_next;
        rnd_a_reg  <= rnd_a_next;
        rnd_b_reg  <= rnd_b_next;
        rnd_c_reg  <= rnd_c_next;
        rcnt_reg   <= rcnt_next;
        round_reg  <= round_next;
        macc_reg   <= macc_next;
        madd_reg   <= madd_next;
        my_reg     <= my_next;
        result_reg <= result_next;
        out_bit_reg <= out_bit_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(mrpt_pkg::M_TDATA_W-1)'(0), out_bit_reg};

endmodule
